[design/tlbpt_pkg.sv]
// Shared types and constants for the TLB / page-table translator.
// No dependencies; used by tlbpt_ctrl, tlbpt_datapath and the top level.
package tlbpt_pkg;

	// Address split and field widths
	localparam int VA_W        = 16;
	localparam int OFFSET_BITS = 8;
	localparam int PAGE_W      = 8;
	localparam int FRAME_W     = 8;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_COUNT = 256;
	localparam int LIMIT_W     = 9;
	localparam int CNT_W       = 32;

	// frames_in_use after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	// Controller -> datapath commands
	typedef struct packed {
		logic capture;     // latch the incoming address
		logic hit_done;    // TLB hit: take frame from TLB
		logic pm_hit;      // page table hit: take frame from page map
		logic fill;        // fault with a free frame
		logic fault_full;  // fault with all frames taken: start eviction
		logic victim_rd;   // owner data valid: read victim's page map entry
		logic evict;       // finish eviction and all table updates
		logic emit;        // load the output register
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic tlb_hit;
		logic page_valid;
		logic mem_full;
	} status_t;

endpackage

[design/tlbpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[design/tlbpt_ctrl.sv]
// Sequencing state machine for the translator: handshakes and datapath commands.
// Depends on tlbpt_pkg (cmd_t, status_t).
module tlbpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  tlbpt_pkg::status_t sts,
	output tlbpt_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_PM    = 3'd2;
	localparam logic [2:0] ST_OWN   = 3'd3;
	localparam logic [2:0] ST_EVICT = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.hit_done   = (state_q == ST_LOOK) && sts.tlb_hit;
		cmd.pm_hit     = (state_q == ST_PM) && sts.page_valid;
		cmd.fill       = (state_q == ST_PM) && !sts.page_valid && !sts.mem_full;
		cmd.fault_full = (state_q == ST_PM) && !sts.page_valid && sts.mem_full;
		cmd.victim_rd  = (state_q == ST_OWN);
		cmd.evict      = (state_q == ST_EVICT);
		cmd.emit       = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = sts.tlb_hit ? ST_DONE : ST_PM;
			end
			ST_PM: begin
				if (!sts.page_valid && sts.mem_full) state_d = ST_OWN;
				else state_d = ST_DONE;
			end
			ST_OWN: begin
				state_d = ST_EVICT;
			end
			ST_EVICT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// at most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.hit_done, cmd.pm_hit, cmd.fill, cmd.fault_full,
			cmd.victim_rd, cmd.evict, cmd.emit}))
		else $error("more than one datapath command active");

	// eviction finishes only after the owner read
	a_evict_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> ($past(state_q) == ST_OWN))
		else $error("eviction entered without owner read");

	// an accepted beat starts the lookup
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_LOOK))
		else $error("accepted beat did not start a lookup");

	// a loaded result is presented
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("result loaded but not presented");

endmodule

[design/tlbpt_datapath.sv]
// Translator datapath: TLB, page map, frame owner table, FIFO replacement,
// counters, config register and output register. Depends on tlbpt_pkg, tlbpt_ram.
module tlbpt_datapath #(
	parameter int TLB_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlbpt_pkg::cmd_t                   cmd,
	output tlbpt_pkg::status_t                sts,
	input  logic                              cfg_wr_en,
	input  logic [tlbpt_pkg::LIMIT_W-1:0]     cfg_wr_data,
	input  logic [tlbpt_pkg::VA_W-1:0]        virtual_address,
	output logic [tlbpt_pkg::VA_W-1:0]        physical_address,
	output logic [tlbpt_pkg::FRAME_W-1:0]     frame_number,
	output logic                              tlb_hit,
	output logic                              page_fault,
	output logic                              evicted,
	output logic [tlbpt_pkg::PAGE_W-1:0]      evicted_page,
	output logic [tlbpt_pkg::CNT_W-1:0]       hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]       fault_total
);

	localparam int TLB_IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int PW = tlbpt_pkg::PAGE_W;
	localparam int FW = tlbpt_pkg::FRAME_W;
	localparam int LW = tlbpt_pkg::LIMIT_W;
	localparam int CW = tlbpt_pkg::CNT_W;
	localparam int OB = tlbpt_pkg::OFFSET_BITS;

	// request and config
	logic [tlbpt_pkg::VA_W-1:0] va_q;
	logic [LW-1:0]              frames_in_use_q;
	logic [PW-1:0]              page;
	logic [LW-1:0]              lim;

	// replacement state
	logic [LW-1:0] filled_q;
	logic [FW-1:0] oldest_ptr_q;
	logic [FW-1:0] victim_frame;
	logic [FW-1:0] victim_frame_q;
	logic [PW-1:0] victim_q;
	logic [LW-1:0] ptr_inc;
	logic          mem_full;

	// page map valid bits and memories
	logic [tlbpt_pkg::PAGE_COUNT-1:0] pm_valid_q;
	logic          pm_wr_en;
	logic [FW-1:0] pm_wr_data;
	logic [PW-1:0] pm_rd_addr;
	logic [FW-1:0] pm_rd_data;
	logic [FW-1:0] own_wr_addr;
	logic [PW-1:0] own_rd_data;
	logic          victim_stale_n;

	// TLB
	logic [TLB_DEPTH-1:0] tlb_valid_q;
	logic [PW-1:0]        tlb_page_q  [TLB_DEPTH];
	logic [FW-1:0]        tlb_frame_q [TLB_DEPTH];
	logic [TLB_IDX_W-1:0] tlb_slot_q;
	logic [PW-1:0]        tlb_key;
	logic                 tlb_match;
	logic [TLB_IDX_W-1:0] tlb_idx;
	logic                 tlb_wr;
	logic [FW-1:0]        tlb_wr_frame;

	// result and counters
	logic [FW-1:0] res_frame_q;
	logic          res_hit_q;
	logic          res_fault_q;
	logic          res_ev_q;
	logic [PW-1:0] res_evpage_q;
	logic [CW-1:0] hit_cnt_q;
	logic [CW-1:0] fault_cnt_q;

	// output register
	logic [tlbpt_pkg::VA_W-1:0] out_pa_q;
	logic [FW-1:0]              out_frame_q;
	logic                       out_hit_q;
	logic                       out_fault_q;
	logic                       out_ev_q;
	logic [PW-1:0]              out_evpage_q;
	logic [CW-1:0]              out_hits_q;
	logic [CW-1:0]              out_faults_q;

	assign page = va_q[OB +: PW];

	// frame limit clamped to 1..FRAME_COUNT
	always_comb begin
		if (frames_in_use_q == '0) lim = LW'(1);
		else if (frames_in_use_q > LW'(tlbpt_pkg::FRAME_COUNT)) lim = LW'(tlbpt_pkg::FRAME_COUNT);
		else lim = frames_in_use_q;
	end

	assign mem_full     = (filled_q >= lim);
	assign victim_frame = ({1'b0, oldest_ptr_q} >= lim) ? '0 : oldest_ptr_q;
	assign ptr_inc      = {1'b0, victim_frame_q} + LW'(1);

	// priority search, lowest index wins
	assign tlb_key = cmd.evict ? victim_q : page;
	always_comb begin
		tlb_match = 1'b0;
		tlb_idx   = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (tlb_valid_q[i] && (tlb_page_q[i] == tlb_key)) begin
				tlb_match = 1'b1;
				tlb_idx   = TLB_IDX_W'(i);
			end
		end
	end

	assign sts.tlb_hit    = tlb_match;
	assign sts.page_valid = pm_valid_q[page];
	assign sts.mem_full   = mem_full;

	// memory port steering
	assign pm_wr_en    = cmd.fill || cmd.evict;
	assign pm_wr_data  = cmd.fill ? filled_q[FW-1:0] : victim_frame_q;
	assign pm_rd_addr  = cmd.victim_rd ? own_rd_data : page;
	assign own_wr_addr = cmd.fill ? filled_q[FW-1:0] : victim_frame_q;

	tlbpt_ram #(.WIDTH(FW), .DEPTH(tlbpt_pkg::PAGE_COUNT)) u_page_map (
		.clk     (clk),
		.wr_en   (pm_wr_en),
		.wr_addr (page),
		.wr_data (pm_wr_data),
		.rd_addr (pm_rd_addr),
		.rd_data (pm_rd_data)
	);

	tlbpt_ram #(.WIDTH(PW), .DEPTH(tlbpt_pkg::FRAME_COUNT)) u_frame_owner (
		.clk     (clk),
		.wr_en   (pm_wr_en),
		.wr_addr (own_wr_addr),
		.wr_data (page),
		.rd_addr (victim_frame),
		.rd_data (own_rd_data)
	);

	// victim entry is dropped only if it still maps to the victim frame
	assign victim_stale_n = pm_valid_q[victim_q] && (pm_rd_data == victim_frame_q);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= tlbpt_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			frames_in_use_q <= cfg_wr_data;
		end
	end

	// request capture and eviction scratch
	always_ff @(posedge clk) begin
		if (cmd.capture) va_q <= virtual_address;
		if (cmd.fault_full) victim_frame_q <= victim_frame;
		if (cmd.victim_rd) victim_q <= own_rd_data;
	end

	// replacement state and page map valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q     <= '0;
			oldest_ptr_q <= '0;
			pm_valid_q   <= '0;
		end else begin
			if (cmd.fill) begin
				filled_q         <= filled_q + LW'(1);
				pm_valid_q[page] <= 1'b1;
			end
			if (cmd.evict) begin
				oldest_ptr_q <= (ptr_inc >= lim) ? '0 : ptr_inc[FW-1:0];
				if (victim_stale_n) pm_valid_q[victim_q] <= 1'b0;
				pm_valid_q[page] <= 1'b1;
			end
		end
	end

	// TLB fill at the round-robin slot
	assign tlb_wr = cmd.pm_hit || cmd.fill || cmd.evict;
	always_comb begin
		if (cmd.pm_hit) tlb_wr_frame = pm_rd_data;
		else if (cmd.fill) tlb_wr_frame = filled_q[FW-1:0];
		else tlb_wr_frame = victim_frame_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q <= '0;
			tlb_slot_q  <= '0;
		end else if (tlb_wr) begin
			tlb_valid_q[tlb_slot_q] <= 1'b1;
			tlb_slot_q <= (tlb_slot_q == TLB_IDX_W'(TLB_DEPTH - 1)) ? '0
				: tlb_slot_q + TLB_IDX_W'(1);
		end
	end

	// rename the victim's entry, then the slot write (slot write wins)
	always_ff @(posedge clk) begin
		if (cmd.evict && tlb_match) tlb_page_q[tlb_idx] <= page;
		if (tlb_wr) begin
			tlb_page_q[tlb_slot_q]  <= page;
			tlb_frame_q[tlb_slot_q] <= tlb_wr_frame;
		end
	end

	// saturating statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else begin
			if (cmd.hit_done && (hit_cnt_q != '1)) hit_cnt_q <= hit_cnt_q + CW'(1);
			if ((cmd.fill || cmd.fault_full) && (fault_cnt_q != '1)) begin
				fault_cnt_q <= fault_cnt_q + CW'(1);
			end
		end
	end

	// per-item result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_hit_q    <= 1'b0;
			res_fault_q  <= 1'b0;
			res_ev_q     <= 1'b0;
			res_evpage_q <= '0;
		end
		if (cmd.hit_done) begin
			res_frame_q <= tlb_frame_q[tlb_idx];
			res_hit_q   <= 1'b1;
		end
		if (cmd.pm_hit) res_frame_q <= pm_rd_data;
		if (cmd.fill) begin
			res_frame_q <= filled_q[FW-1:0];
			res_fault_q <= 1'b1;
		end
		if (cmd.fault_full) res_fault_q <= 1'b1;
		if (cmd.evict) begin
			res_frame_q  <= victim_frame_q;
			res_ev_q     <= 1'b1;
			res_evpage_q <= victim_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pa_q     <= {res_frame_q, va_q[OB-1:0]};
			out_frame_q  <= res_frame_q;
			out_hit_q    <= res_hit_q;
			out_fault_q  <= res_fault_q;
			out_ev_q     <= res_ev_q;
			out_evpage_q <= res_evpage_q;
			out_hits_q   <= hit_cnt_q;
			out_faults_q <= fault_cnt_q;
		end
	end

	assign physical_address = out_pa_q;
	assign frame_number     = out_frame_q;
	assign tlb_hit          = out_hit_q;
	assign page_fault       = out_fault_q;
	assign evicted          = out_ev_q;
	assign evicted_page     = out_evpage_q;
	assign hit_total        = out_hits_q;
	assign fault_total      = out_faults_q;

	// victim frame always lies below the active limit
	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |-> ({1'b0, victim_frame_q} < lim))
		else $error("victim frame outside frame limit");

	// a fill never passes the limit
	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill |=> (filled_q <= lim))
		else $error("frame fill count passed the limit");

	// a hit leaves a nonzero hit count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_done |=> (hit_cnt_q != '0))
		else $error("hit counter did not advance");

endmodule

[design/tlb_page_table_translator_top.sv]
// Top level of the TLB / page-table address translator.
// Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_datapath (and tlbpt_ram through it).
//
// Usage:
//   Input channel: in_valid / in_stall with virtual_address (page = bits 15:8,
//   offset = bits 7:0). Output channel: out_valid / out_stall with the
//   translated address, frame, hit/fault/eviction flags and running totals.
//   A beat moves on a clock edge where valid is high and stall is low.
//   Config: cfg_wr_en / cfg_wr_data write frames_in_use (reset 256); write
//   only while the block is idle.
// Sequence: one item at a time. An accepted item passes the lookup state; on
//   a TLB miss the page-table state follows, and a fault that evicts adds the
//   owner read, then the victim page-map read (both through the registered RAM
//   ports). out_valid rises on the same edge at which the controller returns
//   to idle. The result sits in an output register, so a new item is taken
//   while the previous result waits.
// Reset (arst_n low): TLB and page-map valid bits, fill count, FIFO pointer,
//   counters and handshakes clear at once; no clearing pass is needed.
// Stall: while out_stall holds a result, a finished item waits in its last
//   state and in_stall stays high until the output register frees up.
module tlb_page_table_translator_top #(
	parameter int TLB_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tlbpt_pkg::VA_W-1:0]    virtual_address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tlbpt_pkg::VA_W-1:0]    physical_address,
	output logic [tlbpt_pkg::FRAME_W-1:0] frame_number,
	output logic                          tlb_hit,
	output logic                          page_fault,
	output logic                          evicted,
	output logic [tlbpt_pkg::PAGE_W-1:0]  evicted_page,
	output logic [tlbpt_pkg::CNT_W-1:0]   hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]   fault_total,
	input  logic                          cfg_wr_en,
	input  logic [tlbpt_pkg::LIMIT_W-1:0] cfg_wr_data
);

	tlbpt_pkg::cmd_t    cmd;
	tlbpt_pkg::status_t sts;

	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlbpt_datapath #(.TLB_DEPTH(TLB_DEPTH)) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.virtual_address  (virtual_address),
		.physical_address (physical_address),
		.frame_number     (frame_number),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault),
		.evicted          (evicted),
		.evicted_page     (evicted_page),
		.hit_total        (hit_total),
		.fault_total      (fault_total)
	);

endmodule
